// ===== design/pwa_pkg.sv =====
// Package for the periodic waveform animator: fixed-point constants, register
// and waveform codes, the wrapped-phase helper and the quarter-wave sine ROM.
// No dependencies.
`default_nettype none

package pwa_pkg;

  localparam int FRAC_BITS = 16;
  localparam int SINE_BITS = 10;
  localparam int QTR_BITS  = SINE_BITS - 2;
  localparam int QTR_N     = 1 << QTR_BITS;
  localparam int ONE_Q     = 1 << FRAC_BITS;
  localparam int HALF_Q    = ONE_Q / 2;
  localparam int QUARTER_Q = ONE_Q / 4;
  localparam int ACC_THRESH = ONE_Q / 100;
  localparam longint HALF_PI_Q28 = 64'sd421657428;
  localparam int SIN_W = 30;
  localparam int PH_W  = FRAC_BITS + 2;
  localparam int YW    = FRAC_BITS + 3;

  typedef enum logic [2:0] {
    REG_CONTROL,
    REG_START_DELAY,
    REG_PERIOD_COUNT,
    REG_AMPLITUDE,
    REG_START_SPEED,
    REG_VALUE_OFFSET,
    REG_ACCELERATION,
    REG_QUANT_STEP
  } reg_idx_e;

  typedef enum logic [2:0] {
    WAVE_LINEAR,
    WAVE_SINE,
    WAVE_SQUARE,
    WAVE_SAW,
    WAVE_TRIANGLE
  } wave_e;

  typedef logic signed [SIN_W-1:0] sin_tbl_t [0:QTR_N];

  // Shift-and-subtract quotient for non-negative operands, elaboration only
  function automatic longint udiv_elab(longint n, longint d);
    longint q;
    longint r;
    q = 0;
    r = 0;
    for (int i = 62; i >= 0; i--) begin
      r = (r << 1) | ((n >>> i) & 64'sd1);
      q = q << 1;
      if (r >= d) begin
        r = r - d;
        q = q | 64'sd1;
      end
    end
    return q;
  endfunction

  // Quarter-wave sine in Q2.28, seven-term Taylor series, built at elaboration
  function automatic sin_tbl_t build_sin_tbl();
    sin_tbl_t tbl;
    longint   x;
    longint   x2;
    longint   term;
    longint   sum;
    for (int j = 0; j <= QTR_N; j++) begin
      x    = (longint'(j) * HALF_PI_Q28) >>> QTR_BITS;
      x2   = (x * x) >>> 28;
      term = x;
      sum  = x;
      for (int k = 1; k <= 6; k++) begin
        term = udiv_elab((term * x2) >>> 28, longint'((2 * k) * (2 * k + 1)));
        sum  = ((k & 1) == 1) ? sum - term : sum + term;
      end
      tbl[j] = SIN_W'(sum);
    end
    return tbl;
  endfunction

  localparam sin_tbl_t SIN_TBL = build_sin_tbl();

  // fmod(x + c, 1) with x = +/-mag, sign of the result follows x + c
  function automatic logic signed [PH_W-1:0] wrap_frac(
    input logic                   neg,
    input logic                   big,
    input logic [FRAC_BITS-1:0]   m,
    input logic signed [YW-1:0]   c
  );
    logic signed [YW-1:0] ms;
    logic signed [YW-1:0] y;
    logic signed [YW-1:0] one;
    logic                 sneg;
    one  = YW'(ONE_Q);
    ms   = $signed({3'b000, m});
    y    = (neg ? -ms : ms) + c;
    sneg = big ? neg : y[YW-1];
    if (sneg) begin
      if (y > 0) y = y - one;
      if (y <= -one) y = y + one;
    end else begin
      if (y < 0) y = y + one;
      if (y >= one) y = y - one;
    end
    return PH_W'(y);
  endfunction

endpackage

`default_nettype wire

// ===== design/periodic_waveform_animator.sv =====
// Periodic waveform animator (LFO): top level with registers, sequencer and
// shared 34x34 multiplier. Depends on pwa_pkg and pwa_udiv.
//
// Usage: each beat on the s_axis channel is a time tick (Q0.16 seconds). The
// block counts down the start delay, advances elapsed time, ramps speed, and
// returns one beat on m_axis: the offset plus the selected waveform, with the
// delay_ended, expired and animating flags.
// A tick passes from acceptance to a valid result through a chain of steps on
// the one shared multiplier (acceleration, two time x speed partial products,
// amplitude scaling). With quant_step nonzero the result then also passes
// through the bit-serial quantization divider.
// s_axis_tready is high only while the sequencer is idle; the next tick is
// taken as soon as the result sits in the output register.
// If the receiver stalls, the result waits in the output register; a second
// result waits in the sequencer until the first beat is taken.
// Reset loads the register defaults, clears elapsed time, loads the delay and
// speed from their registers and drops m_axis_tvalid.
// Registers sit on the APB port at byte address 4*index; pready is always high.
`default_nettype none

module periodic_waveform_animator (
  input  wire         clk_i,
  input  wire         rst_ni,
  input  wire         s_axis_tvalid,
  output logic        s_axis_tready,
  input  wire  [15:0] s_axis_tdata,   // [15:0] tick_delta
  output logic        m_axis_tvalid,
  input  wire         m_axis_tready,
  output logic [39:0] m_axis_tdata,   // [31:0] wave_value, [32] delay_ended,
                                      // [33] expired, [34] animating
  input  wire         psel,
  input  wire         penable,
  input  wire         pwrite,
  input  wire  [4:0]  paddr,
  input  wire  [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  typedef enum logic [3:0] {
    S_IDLE, S_LOAD, S_ACC, S_SPD, S_MH, S_ML, S_EXP, S_WAVE,
    S_MULW, S_SHR, S_LIN2, S_LIN3, S_SUM, S_QST, S_DIV, S_OUT
  } state_e;

  localparam int PW = pwa_pkg::PH_W;
  localparam int YW = pwa_pkg::YW;

  state_e             state_q;
  logic [4:0]         ctl_q;
  logic [30:0]        sdel_q;
  logic signed [31:0] pc_q;
  logic signed [31:0] amp_q;
  logic signed [23:0] sspd_q;
  logic signed [31:0] ofs_q;
  logic signed [23:0] acc_q;
  logic [15:0]        qs_q;

  logic [47:0]        elapsed_q;
  logic [30:0]        dleft_q;
  logic signed [23:0] spd_q;

  logic [15:0]        tick_q;
  logic [15:0]        dt_q;
  logic               adv_q;
  logic               ended_q;
  logic               expired_q;
  logic               anim_q;
  logic               neg_q;
  logic [56:0]        mag_q;
  logic [47:0]        ph_q;
  logic [63:0]        lin_hi_q;
  logic signed [33:0] opa_q;
  logic               lin_q;
  logic               sine_q;
  logic signed [42:0] res_q;
  logic signed [31:0] v_q;
  logic               m_valid_q;
  logic [39:0]        m_data_q;
  logic signed [67:0] p_q;

  logic               en;
  logic               cfg_wr;
  logic [23:0]        acc_abs;
  logic [23:0]        sabs;
  logic [31:0]        amp_abs;
  logic [31:0]        pc_abs;
  logic signed [33:0] mul_a;
  logic signed [33:0] mul_b;
  logic [48:0]        e_sum;
  logic signed [25:0] spd_sum;
  logic signed [23:0] spd_new;
  logic [71:0]        prod72;
  logic               exp_w;
  logic               anim_w;
  logic               big;
  logic signed [PW-1:0] w0;
  logic signed [PW-1:0] wh;
  logic signed [PW-1:0] wq;
  logic signed [YW-1:0] gh;
  logic signed [YW-1:0] gq;
  logic [1:0]         quad;
  logic [pwa_pkg::QTR_BITS:0] sin_j;
  logic signed [pwa_pkg::SIN_W-1:0] sin_mag;
  logic signed [pwa_pkg::SIN_W-1:0] sin_val;
  logic [40:0]        q_int;
  logic [40:0]        q_clamp;
  logic signed [67:0] psh;
  logic [64:0]        m65;
  logic [40:0]        mcl;
  logic signed [43:0] sum44;
  logic signed [31:0] v_sat;
  logic [31:0]        v_abs;
  logic [15:0]        q_mag;
  logic [31:0]        q_val;
  logic               div_start;
  logic               div_done;
  logic [15:0]        div_rem;

  assign en            = ctl_q[4];
  assign cfg_wr        = psel & penable & pwrite;
  assign pready        = 1'b1;
  assign s_axis_tready = (state_q == S_IDLE);
  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = m_data_q;
  assign div_start     = (state_q == S_QST);

  always_comb begin
    case (paddr[4:2])
      pwa_pkg::REG_CONTROL:      prdata = {27'b0, ctl_q};
      pwa_pkg::REG_START_DELAY:  prdata = {1'b0, sdel_q};
      pwa_pkg::REG_PERIOD_COUNT: prdata = pc_q;
      pwa_pkg::REG_AMPLITUDE:    prdata = amp_q;
      pwa_pkg::REG_START_SPEED:  prdata = 32'(sspd_q);
      pwa_pkg::REG_VALUE_OFFSET: prdata = ofs_q;
      pwa_pkg::REG_ACCELERATION: prdata = 32'(acc_q);
      pwa_pkg::REG_QUANT_STEP:   prdata = {16'b0, qs_q};
      default:                   prdata = '0;
    endcase
  end

  always_comb begin
    acc_abs = acc_q[23] ? 24'(-acc_q) : 24'(acc_q);
    sabs    = spd_q[23] ? 24'(-spd_q) : 24'(spd_q);
    amp_abs = amp_q[31] ? 32'(-amp_q) : 32'(amp_q);
    pc_abs  = pc_q[31] ? 32'(-pc_q) : 32'(pc_q);

    e_sum   = {1'b0, elapsed_q} + 49'(dt_q);
    spd_sum = 26'(spd_q) + $signed(p_q[41:16]);
    if (!spd_sum[25] && spd_sum[24:23] != 2'b00) spd_new = 24'sh7FFFFF;
    else if (spd_sum[25] && spd_sum[24:23] != 2'b11) spd_new = -24'sh800000;
    else spd_new = spd_sum[23:0];

    prod72 = {ph_q, 24'b0} + {24'b0, p_q[47:0]};
    exp_w  = !en || (!pc_q[31] && sabs != '0 &&
             prod72 > {25'b0, pc_q[30:0], 16'b0});
    anim_w = en && dleft_q == '0 && !exp_w;

    big = |mag_q[56:16];
    w0  = pwa_pkg::wrap_frac(neg_q, big, mag_q[15:0], YW'(0));
    wh  = pwa_pkg::wrap_frac(neg_q, big, mag_q[15:0], YW'(pwa_pkg::HALF_Q));
    wq  = pwa_pkg::wrap_frac(neg_q, big, mag_q[15:0], YW'(-pwa_pkg::QUARTER_Q));
    gh  = YW'(wh) - YW'(pwa_pkg::HALF_Q);
    gq  = YW'(wq) - YW'(pwa_pkg::QUARTER_Q);

    quad    = w0[pwa_pkg::FRAC_BITS-1 -: 2];
    sin_j   = {1'b0, w0[pwa_pkg::FRAC_BITS-3 -: pwa_pkg::QTR_BITS]};
    if (quad[0]) sin_j = (pwa_pkg::QTR_BITS+1)'(pwa_pkg::QTR_N) - sin_j;
    sin_mag = pwa_pkg::SIN_TBL[sin_j];
    sin_val = quad[1] ? -sin_mag : sin_mag;

    q_int   = mag_q[56:16];
    q_clamp = (q_int > (41'd1 << 32)) ? (41'd1 << 32) : q_int;

    psh = sine_q ? (p_q >>> 28) : (p_q >>> pwa_pkg::FRAC_BITS);
    m65 = {1'b0, lin_hi_q} + {33'b0, p_q[47:16]};
    mcl = (m65 > (65'd1 << 40)) ? (41'd1 << 40) : m65[40:0];

    sum44 = 44'(res_q) + 44'(ofs_q);
    if (!sum44[43] && sum44[42:31] != '0) v_sat = 32'sh7FFFFFFF;
    else if (sum44[43] && sum44[42:31] != '1) v_sat = -32'sh80000000;
    else v_sat = sum44[31:0];

    v_abs = v_q[31] ? 32'(-v_q) : 32'(v_q);
    q_mag = v_abs[31:16] - div_rem;
    q_val = {q_mag, 16'b0};
  end

  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (state_q)
      S_ACC: begin
        mul_a = 34'(acc_q);
        mul_b = $signed({18'b0, dt_q});
      end
      S_MH: begin
        mul_a = $signed({10'b0, elapsed_q[47:24]});
        mul_b = $signed({10'b0, sabs});
      end
      S_ML: begin
        mul_a = $signed({10'b0, elapsed_q[23:0]});
        mul_b = $signed({10'b0, sabs});
      end
      S_MULW: begin
        mul_a = opa_q;
        mul_b = lin_q ? $signed({2'b0, amp_abs}) : 34'(amp_q);
      end
      S_LIN2: begin
        mul_a = $signed({18'b0, mag_q[15:0]});
        mul_b = $signed({2'b0, amp_abs});
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    p_q <= mul_a * mul_b;
  end

  pwa_udiv #(
    .W(16)
  ) u_qdiv (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (v_abs[31:16]),
    .divisor_i  (qs_q),
    .done_o     (div_done),
    .rem_o      (div_rem)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_IDLE;
      ctl_q     <= 5'd16;
      sdel_q    <= '0;
      pc_q      <= 32'sd65536;
      amp_q     <= 32'sd32768;
      sspd_q    <= 24'sd65536;
      ofs_q     <= '0;
      acc_q     <= '0;
      qs_q      <= '0;
      elapsed_q <= '0;
      dleft_q   <= '0;
      spd_q     <= 24'sd65536;
      tick_q    <= '0;
      dt_q      <= '0;
      adv_q     <= 1'b0;
      ended_q   <= 1'b0;
      expired_q <= 1'b0;
      anim_q    <= 1'b0;
      neg_q     <= 1'b0;
      mag_q     <= '0;
      ph_q      <= '0;
      lin_hi_q  <= '0;
      opa_q     <= '0;
      lin_q     <= 1'b0;
      sine_q    <= 1'b0;
      res_q     <= '0;
      v_q       <= '0;
      m_valid_q <= 1'b0;
      m_data_q  <= '0;
    end else begin
      if (m_valid_q && m_axis_tready && state_q != S_OUT) m_valid_q <= 1'b0;

      if (cfg_wr) begin
        case (paddr[4:2])
          pwa_pkg::REG_CONTROL:      ctl_q <= pwdata[4:0];
          pwa_pkg::REG_START_DELAY: begin
            sdel_q  <= pwdata[30:0];
            dleft_q <= pwdata[30:0];
          end
          pwa_pkg::REG_PERIOD_COUNT: pc_q <= pwdata;
          pwa_pkg::REG_AMPLITUDE:    amp_q <= pwdata;
          pwa_pkg::REG_START_SPEED: begin
            sspd_q <= pwdata[23:0];
            spd_q  <= pwdata[23:0];
          end
          pwa_pkg::REG_VALUE_OFFSET: ofs_q <= pwdata;
          pwa_pkg::REG_ACCELERATION: acc_q <= pwdata[23:0];
          pwa_pkg::REG_QUANT_STEP:   qs_q <= pwdata[15:0];
          default: ;
        endcase
      end

      case (state_q)
        S_IDLE: begin
          if (s_axis_tvalid) begin
            tick_q  <= s_axis_tdata;
            state_q <= S_LOAD;
          end
        end
        S_LOAD: begin
          adv_q   <= 1'b0;
          ended_q <= 1'b0;
          dt_q    <= tick_q;
          if (en) begin
            if (dleft_q != '0) begin
              if ({15'b0, tick_q} < dleft_q) begin
                dleft_q <= dleft_q - {15'b0, tick_q};
              end else begin
                dt_q    <= tick_q - dleft_q[15:0];
                dleft_q <= '0;
                ended_q <= 1'b1;
                adv_q   <= 1'b1;
              end
            end else begin
              adv_q <= 1'b1;
            end
          end
          state_q <= S_ACC;
        end
        S_ACC: begin
          if (adv_q) elapsed_q <= e_sum[48] ? '1 : e_sum[47:0];
          state_q <= S_SPD;
        end
        S_SPD: begin
          if (adv_q && acc_abs > 24'(pwa_pkg::ACC_THRESH)) spd_q <= spd_new;
          state_q <= S_MH;
        end
        S_MH: begin
          state_q <= S_ML;
        end
        S_ML: begin
          ph_q    <= p_q[47:0];
          state_q <= S_EXP;
        end
        S_EXP: begin
          expired_q <= exp_w;
          anim_q    <= anim_w;
          if (dleft_q != '0 || (exp_w && ctl_q[3])) begin
            res_q   <= '0;
            state_q <= S_SUM;
          end else begin
            if (exp_w) begin
              if (spd_q == '0) begin
                neg_q <= 1'b0;
                mag_q <= '0;
              end else begin
                neg_q <= pc_q[31] ^ spd_q[23];
                mag_q <= {25'b0, pc_abs};
              end
            end else begin
              neg_q <= spd_q[23];
              mag_q <= {1'b0, ph_q, 8'b0} + {25'b0, p_q[47:16]};
            end
            state_q <= S_WAVE;
          end
        end
        S_WAVE: begin
          lin_q  <= 1'b0;
          sine_q <= 1'b0;
          case (ctl_q[2:0])
            pwa_pkg::WAVE_LINEAR: begin
              opa_q   <= $signed(q_clamp[33:0]);
              lin_q   <= 1'b1;
              state_q <= S_MULW;
            end
            pwa_pkg::WAVE_SINE: begin
              opa_q   <= 34'(sin_val);
              sine_q  <= 1'b1;
              state_q <= S_MULW;
            end
            pwa_pkg::WAVE_SQUARE: begin
              res_q   <= (w0 < PW'(pwa_pkg::HALF_Q)) ? 43'(amp_q) : -43'(amp_q);
              state_q <= S_SUM;
            end
            pwa_pkg::WAVE_SAW: begin
              opa_q   <= 34'(gh) <<< 1;
              state_q <= S_MULW;
            end
            pwa_pkg::WAVE_TRIANGLE: begin
              if (w0 < PW'(pwa_pkg::QUARTER_Q) || w0 >= PW'(3 * pwa_pkg::QUARTER_Q))
                opa_q <= 34'(gh) <<< 2;
              else
                opa_q <= -(34'(gq) <<< 2);
              state_q <= S_MULW;
            end
            default: begin
              res_q   <= '0;
              state_q <= S_SUM;
            end
          endcase
        end
        S_MULW: begin
          state_q <= lin_q ? S_LIN2 : S_SHR;
        end
        S_SHR: begin
          res_q   <= psh[42:0];
          state_q <= S_SUM;
        end
        S_LIN2: begin
          lin_hi_q <= p_q[63:0];
          state_q  <= S_LIN3;
        end
        S_LIN3: begin
          res_q   <= (neg_q ^ amp_q[31]) ? -$signed({2'b0, mcl}) : $signed({2'b0, mcl});
          state_q <= S_SUM;
        end
        S_SUM: begin
          v_q     <= v_sat;
          state_q <= (qs_q == '0) ? S_OUT : S_QST;
        end
        S_QST: begin
          state_q <= S_DIV;
        end
        S_DIV: begin
          if (div_done) begin
            v_q     <= v_q[31] ? 32'(-q_val) : q_val;
            state_q <= S_OUT;
          end
        end
        S_OUT: begin
          if (!m_valid_q || m_axis_tready) begin
            m_valid_q <= 1'b1;
            m_data_q  <= {5'b0, anim_q, expired_q, ended_q, v_q};
            state_q   <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

endmodule

`default_nettype wire

// ===== design/pwa_udiv.sv =====
// Restoring unsigned divider, one quotient bit per cycle, remainder only.
// No dependencies.
`default_nettype none

module pwa_udiv #(
  parameter int W = 16
) (
  input  wire          clk_i,
  input  wire          rst_ni,
  input  wire          start_i,
  input  wire [W-1:0]  dividend_i,
  input  wire [W-1:0]  divisor_i,
  output logic         done_o,
  output logic [W-1:0] rem_o
);

  localparam int CW = $clog2(W + 1);

  logic          busy_q;
  logic          done_q;
  logic [CW-1:0] cnt_q;
  logic [W-1:0]  num_q;
  logic [W-1:0]  rem_q;
  logic [W:0]    trial;
  logic [W:0]    diff;

  assign trial  = {rem_q, num_q[W-1]};
  assign diff   = trial - {1'b0, divisor_i};
  assign done_o = done_q;
  assign rem_o  = rem_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
      num_q  <= '0;
      rem_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
        num_q  <= dividend_i;
        rem_q  <= '0;
      end else if (busy_q) begin
        rem_q <= diff[W] ? trial[W-1:0] : diff[W-1:0];
        num_q <= num_q << 1;
        cnt_q <= cnt_q + 1'b1;
        if (cnt_q == CW'(W - 1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

endmodule

`default_nettype wire

// ===== design/pwa_checker.sv =====
// Port-level checks for the periodic waveform animator, bound to the top level.
// Depends on periodic_waveform_animator.
`default_nettype none

module pwa_checker (
  input wire        clk_i,
  input wire        rst_ni,
  input wire        s_axis_tvalid,
  input wire        s_axis_tready,
  input wire        m_axis_tvalid,
  input wire        m_axis_tready,
  input wire [39:0] m_axis_tdata
);

  // result beat stays offered until taken
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
    else $error("result beat dropped while stalled");

  // one tick at a time: busy right after a tick is taken
  a_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
    else $error("tick accepted while busy");

  a_anim_exp: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> !(m_axis_tdata[34] && m_axis_tdata[33]))
    else $error("animating and expired both set");

  // delay end implies enabled with no delay left, so exactly one of animating and expired is set
  a_delay_end: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tdata[32] |-> m_axis_tdata[34] != m_axis_tdata[33])
    else $error("delay ended with inconsistent status");

endmodule

bind periodic_waveform_animator pwa_checker u_pwa_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata)
);

`default_nettype wire
